/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks written in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

`endif

/* rtl/ccvi_pkg.sv */
// ---------------------------------------------------------------------------
// ccvi_pkg
// Types, codes and weight tables for the cube cell volume integrator.
// ---------------------------------------------------------------------------
package ccvi_pkg;

    localparam int INDEX_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int VOL_BITS        = 42;
    localparam int FORM_BITS       = 3;
    localparam int WEIGHT_BITS     = 7;
    localparam int N_CORNERS       = 8;
    localparam int SEL_BITS        = 4;

    typedef logic [SEL_BITS-1:0]    sel_t;
    typedef logic [FORM_BITS-1:0]   form_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;

    // Case selected by the inside count and the corner tests.
    localparam sel_t SEL_NONE = 4'd0;
    localparam sel_t SEL_F1   = 4'd1;
    localparam sel_t SEL_F2_G = 4'd2;
    localparam sel_t SEL_F2_D = 4'd3;
    localparam sel_t SEL_F2_F = 4'd4;
    localparam sel_t SEL_F3_A = 4'd5;
    localparam sel_t SEL_F3_B = 4'd6;
    localparam sel_t SEL_F3_G = 4'd7;
    localparam sel_t SEL_F4_G = 4'd8;
    localparam sel_t SEL_F4_D = 4'd9;
    localparam sel_t SEL_F4_F = 4'd10;
    localparam sel_t SEL_F5   = 4'd11;

    localparam form_t FORM_NONE = 3'd0;
    localparam form_t FORM_1    = 3'd1;
    localparam form_t FORM_2    = 3'd2;
    localparam form_t FORM_3    = 3'd3;
    localparam form_t FORM_4    = 3'd4;
    localparam form_t FORM_5    = 3'd5;

    // Control that travels alongside each beat through the pipeline.
    typedef struct packed {
        logic  valid;
        form_t formula;
    } tag_t;

    function automatic form_t sel_formula(input sel_t sel);
        form_t f;
        unique case (sel)
            SEL_F1:                       f = FORM_1;
            SEL_F2_G, SEL_F2_D, SEL_F2_F: f = FORM_2;
            SEL_F3_A, SEL_F3_B, SEL_F3_G: f = FORM_3;
            SEL_F4_G, SEL_F4_D, SEL_F4_F: f = FORM_4;
            SEL_F5:                       f = FORM_5;
            default:                      f = FORM_NONE;
        endcase
        return f;
    endfunction

    // Weight applied to one physical corner. Each formula weights the
    // slots a..h; the permutation says which corner fills each slot, so
    // the corner's weight is that of the slot it lands in.
    function automatic weight_t cube_weight(input sel_t sel, input logic [2:0] corner);
        logic [2:0] perm [N_CORNERS];
        weight_t    base [N_CORNERS];
        weight_t    w;
        perm = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
        base = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
        w    = '0;
        unique case (sel)
            SEL_F1:
            begin
                base = '{7'd33, 7'd33, 7'd33, 7'd51, 7'd33, 7'd51, 7'd51, 7'd75};
            end
            SEL_F2_G, SEL_F2_D, SEL_F2_F:
            begin
                base = '{7'd47, 7'd19, 7'd19, 7'd5, 7'd19, 7'd5, 7'd5, 7'd1};
            end
            SEL_F3_A, SEL_F3_B, SEL_F3_G:
            begin
                base = '{7'd70, 7'd80, 7'd80, 7'd70, 7'd38, 7'd52, 7'd52, 7'd38};
            end
            SEL_F4_G, SEL_F4_D, SEL_F4_F:
            begin
                base = '{7'd89, 7'd85, 7'd85, 7'd71, 7'd85, 7'd71, 7'd71, 7'd43};
            end
            SEL_F5:
            begin
                base = '{7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90};
            end
            default:
            begin
                base = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
            end
        endcase
        unique case (sel)
            SEL_F2_G, SEL_F3_G, SEL_F4_G:
            begin
                perm = '{3'd6, 3'd7, 3'd4, 3'd5, 3'd2, 3'd3, 3'd0, 3'd1};
            end
            SEL_F2_D, SEL_F4_D:
            begin
                perm = '{3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4};
            end
            SEL_F2_F, SEL_F4_F:
            begin
                perm = '{3'd5, 3'd4, 3'd7, 3'd6, 3'd1, 3'd0, 3'd3, 3'd2};
            end
            SEL_F3_A:
            begin
                perm = '{3'd3, 3'd7, 3'd2, 3'd6, 3'd1, 3'd5, 3'd0, 3'd4};
            end
            SEL_F3_B:
            begin
                perm = '{3'd5, 3'd7, 3'd1, 3'd3, 3'd4, 3'd6, 3'd0, 3'd2};
            end
            default:
            begin
                perm = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
            end
        endcase
        for (int p = 0; p < N_CORNERS; p++)
        begin
            if (perm[p] == corner)
            begin
                w = base[p];
            end
        end
        return w;
    endfunction

endpackage

/* rtl/ccvi_inside_lane.sv */
// ---------------------------------------------------------------------------
// ccvi_inside_lane
// One corner: triangle-inequality test on its grid position, registered
// together with its sample.
// ---------------------------------------------------------------------------
module ccvi_inside_lane
    import ccvi_pkg::*;
#(
    parameter int         INDEX_BITS  = INDEX_BITS_DEF,
    parameter int         SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter logic [2:0] CORNER      = 3'd0
)
(
    input  logic                          clk,
    input  logic                          load,
    input  logic [INDEX_BITS-1:0]         index_i,
    input  logic [INDEX_BITS-1:0]         index_j,
    input  logic [INDEX_BITS-1:0]         index_k,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          in_region,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    logic [INDEX_BITS:0]   x, y, z;
    logic [INDEX_BITS+1:0] yz, xz, xy;
    logic                  inside_next;
    logic                  inside_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    always_comb
    begin
        x  = {1'b0, index_i} + {{INDEX_BITS{1'b0}}, CORNER[0]};
        y  = {1'b0, index_j} + {{INDEX_BITS{1'b0}}, CORNER[1]};
        z  = {1'b0, index_k} + {{INDEX_BITS{1'b0}}, CORNER[2]};
        yz = {1'b0, y} + {1'b0, z};
        xz = {1'b0, x} + {1'b0, z};
        xy = {1'b0, x} + {1'b0, y};
        inside_next = !(({1'b0, x} > yz) || ({1'b0, y} > xz) || ({1'b0, z} > xy));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            inside_reg <= inside_next;
            sample_reg <= sample;
        end
    end

    assign in_region  = inside_reg;
    assign sample_out = sample_reg;

endmodule

/* rtl/ccvi_weight_lane.sv */
// ---------------------------------------------------------------------------
// ccvi_weight_lane
// One corner: multiplies its sample by the weight that the selected case
// gives this corner, product registered.
// ---------------------------------------------------------------------------
module ccvi_weight_lane
    import ccvi_pkg::*;
#(
    parameter int         SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter logic [2:0] CORNER      = 3'd0
)
(
    input  logic                                      clk,
    input  logic                                      load,
    input  sel_t                                      sel,
    input  logic signed [SAMPLE_BITS-1:0]             sample,
    output logic signed [SAMPLE_BITS+WEIGHT_BITS:0]   product
);

    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS + 1;

    logic signed [WEIGHT_BITS:0] weight;
    logic signed [PROD_W-1:0]    product_next;
    logic signed [PROD_W-1:0]    product_reg;

    always_comb
    begin
        weight       = signed'({1'b0, cube_weight(sel, CORNER)});
        product_next = PROD_W'(sample) * PROD_W'(weight);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

/* rtl/ccvi_merge.sv */
// ---------------------------------------------------------------------------
// ccvi_merge
// Two-level registered adder tree over the eight lane products; the
// second level is the result register.
// ---------------------------------------------------------------------------
module ccvi_merge
    import ccvi_pkg::*;
#(
    parameter int PROD_W = SAMPLE_BITS_DEF + WEIGHT_BITS + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tag_t                        tag_in,
    input  logic signed [PROD_W-1:0]    product [N_CORNERS],
    output tag_t                        tag_out,
    output logic signed [VOL_BITS-1:0]  volume
);

    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;
    localparam int N_PAIR = N_CORNERS / 2;

    logic signed [PAIR_W-1:0]   pair_next [N_PAIR];
    logic signed [PAIR_W-1:0]   pair_reg  [N_PAIR];
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [VOL_BITS-1:0] volume_reg;
    tag_t                       tag_mid_reg;
    tag_t                       tag_out_reg;

    always_comb
    begin
        for (int p = 0; p < N_PAIR; p++)
        begin
            pair_next[p] = PAIR_W'(product[2*p]) + PAIR_W'(product[2*p+1]);
        end
        sum_next = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1])
                 + SUM_W'(pair_reg[2]) + SUM_W'(pair_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_mid_reg <= '0;
            tag_out_reg <= '0;
        end
        else
        begin
            tag_mid_reg <= tag_in;
            tag_out_reg <= tag_mid_reg;
        end
    end

    // The sum is wrapped to the result width, which matches the exact
    // value whenever it fits.
    always_ff @(posedge clk)
    begin
        if (tag_in.valid)
        begin
            pair_reg <= pair_next;
        end
        if (tag_mid_reg.valid)
        begin
            volume_reg <= VOL_BITS'(sum_next);
        end
    end

    assign tag_out = tag_out_reg;
    assign volume  = volume_reg;

endmodule

/* rtl/cube_cell_volume_integrator.sv */
// ---------------------------------------------------------------------------
// cube_cell_volume_integrator
// Volume integral (times 720) of one grid cube from its eight corner
// samples, choosing the cell formula from the corners inside the region.
// ---------------------------------------------------------------------------
// Channel   Ports                                      Handshake
// input     index_i/j/k, corner_000 .. corner_111       start, busy
// result    volume_x720, formula_used                   done (one-cycle strobe)
//
// A beat is taken at every edge with start high; busy stays low.
// Each result is registered in turn through the corner test, case
// selection, weight multiply and two adder-tree levels.
// Reset clears the valid bits and formula tags of the pipeline; data needs none.
// The receiver cannot stall, so one beat per cycle flows straight through.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cube_cell_volume_integrator
    import ccvi_pkg::*;
#(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [INDEX_BITS-1:0]         index_i,
    input  logic [INDEX_BITS-1:0]         index_j,
    input  logic [INDEX_BITS-1:0]         index_k,
    input  logic signed [SAMPLE_BITS-1:0] corner_000,
    input  logic signed [SAMPLE_BITS-1:0] corner_100,
    input  logic signed [SAMPLE_BITS-1:0] corner_010,
    input  logic signed [SAMPLE_BITS-1:0] corner_110,
    input  logic signed [SAMPLE_BITS-1:0] corner_001,
    input  logic signed [SAMPLE_BITS-1:0] corner_101,
    input  logic signed [SAMPLE_BITS-1:0] corner_011,
    input  logic signed [SAMPLE_BITS-1:0] corner_111,
    output logic                          done,
    output logic signed [VOL_BITS-1:0]    volume_x720,
    output form_t                         formula_used
);

    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS + 1;

    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] corner_in [N_CORNERS];
    logic signed [SAMPLE_BITS-1:0] s1_sample [N_CORNERS];
    logic signed [SAMPLE_BITS-1:0] s2_sample_reg [N_CORNERS];
    logic [N_CORNERS-1:0]          ins;
    logic [3:0]                    count;
    logic                          v1_reg;
    logic                          v2_reg;
    sel_t                          sel_next;
    sel_t                          sel_reg;
    tag_t                          tag3_reg;
    logic signed [PROD_W-1:0]      product [N_CORNERS];
    tag_t                          tag_out;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign corner_in[0] = corner_000;
    assign corner_in[1] = corner_100;
    assign corner_in[2] = corner_010;
    assign corner_in[3] = corner_110;
    assign corner_in[4] = corner_001;
    assign corner_in[5] = corner_101;
    assign corner_in[6] = corner_011;
    assign corner_in[7] = corner_111;

    for (genvar c = 0; c < N_CORNERS; c++)
    begin : g_inside
        ccvi_inside_lane #(
            .INDEX_BITS  (INDEX_BITS),
            .SAMPLE_BITS (SAMPLE_BITS),
            .CORNER      (3'(c))
        ) u_lane (
            .clk        (clk),
            .load       (accept),
            .index_i    (index_i),
            .index_j    (index_j),
            .index_k    (index_k),
            .sample     (corner_in[c]),
            .in_region  (ins[c]),
            .sample_out (s1_sample[c])
        );
    end

    // Later tests in the original order take precedence, so the chains
    // below test in reverse order and take the first hit.
    always_comb
    begin
        count = '0;
        for (int n = 0; n < N_CORNERS; n++)
        begin
            count = count + {3'b000, ins[n]};
        end
        sel_next = SEL_NONE;
        priority case (count)
            4'd4:
            begin
                priority if (ins[6])      sel_next = SEL_F2_G;
                else if (ins[3])          sel_next = SEL_F2_D;
                else if (ins[5])          sel_next = SEL_F2_F;
                else                      sel_next = SEL_NONE;
            end
            4'd5: sel_next = SEL_F1;
            4'd6:
            begin
                priority if (ins[2])      sel_next = SEL_F3_A;
                else if (ins[1])          sel_next = SEL_F3_B;
                else if (ins[4])          sel_next = SEL_F3_G;
                else                      sel_next = SEL_NONE;
            end
            4'd7:
            begin
                priority if (!ins[1])     sel_next = SEL_F4_G;
                else if (!ins[4])         sel_next = SEL_F4_D;
                else if (!ins[2])         sel_next = SEL_F4_F;
                else                      sel_next = SEL_NONE;
            end
            4'd8: sel_next = SEL_F5;
            default: sel_next = SEL_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            tag3_reg <= '0;
        end
        else
        begin
            v1_reg         <= accept;
            v2_reg         <= v1_reg;
            tag3_reg.valid <= v2_reg;
            tag3_reg.formula <= sel_formula(sel_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            sel_reg       <= sel_next;
            s2_sample_reg <= s1_sample;
        end
    end

    for (genvar c = 0; c < N_CORNERS; c++)
    begin : g_weight
        ccvi_weight_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CORNER      (3'(c))
        ) u_lane (
            .clk     (clk),
            .load    (v2_reg),
            .sel     (sel_reg),
            .sample  (s2_sample_reg[c]),
            .product (product[c])
        );
    end

    ccvi_merge #(
        .PROD_W (PROD_W)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag3_reg),
        .product (product),
        .tag_out (tag_out),
        .volume  (volume_x720)
    );

    assign done         = tag_out.valid;
    assign formula_used = tag_out.formula;

    `ASSERT_IMPLIES(a_latency, clk, rst_n, accept, ##5 done)
    `ASSERT_IMPLIES(a_no_orphan, clk, rst_n, done, $past(accept, 5))
    `ASSERT_IMPLIES(a_none_is_zero, clk, rst_n, done && (formula_used == FORM_NONE),
                    volume_x720 == '0)

endmodule

/* dv/cube_cell_volume_integrator_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cube_cell_volume_integrator_tb
// Streams grid cubes into the volume integrator and checks every result
// against an in-bench predictor of the inside test and cell formulas.
// A directed set covers sample extremes and every formula variant. A long
// random stream follows, mostly built on triangle-inequality boundaries.
// ---------------------------------------------------------------------------
module cube_cell_volume_integrator_tb;

    import ccvi_pkg::*;

    localparam int IDX_W     = INDEX_BITS_DEF;
    localparam int SMP_W     = SAMPLE_BITS_DEF;
    localparam int IDX_MAX   = (1 << IDX_W) - 1;
    localparam int RANDOM_CUBES = 750;
    localparam int DRAIN_LIMIT  = 200;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [IDX_W-1:0]                  i;
        logic [IDX_W-1:0]                  j;
        logic [IDX_W-1:0]                  k;
        logic [N_CORNERS-1:0][SMP_W-1:0]   p;
    } cube_t;

    typedef struct packed {
        logic signed [VOL_BITS-1:0] volume;
        form_t                      formula;
    } cell_volume_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [IDX_W-1:0]         index_i;
    logic [IDX_W-1:0]         index_j;
    logic [IDX_W-1:0]         index_k;
    logic signed [SMP_W-1:0]  corner_000;
    logic signed [SMP_W-1:0]  corner_100;
    logic signed [SMP_W-1:0]  corner_010;
    logic signed [SMP_W-1:0]  corner_110;
    logic signed [SMP_W-1:0]  corner_001;
    logic signed [SMP_W-1:0]  corner_101;
    logic signed [SMP_W-1:0]  corner_011;
    logic signed [SMP_W-1:0]  corner_111;
    logic                     done;
    logic signed [VOL_BITS-1:0] volume_x720;
    form_t                    formula_used;

    cell_volume_t pending_volumes [$];
    cell_volume_t oldest_volume;
    int           mismatch_count = 0;

    cube_cell_volume_integrator dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .index_i      (index_i),
        .index_j      (index_j),
        .index_k      (index_k),
        .corner_000   (corner_000),
        .corner_100   (corner_100),
        .corner_010   (corner_010),
        .corner_110   (corner_110),
        .corner_001   (corner_001),
        .corner_101   (corner_101),
        .corner_011   (corner_011),
        .corner_111   (corner_111),
        .done         (done),
        .volume_x720  (volume_x720),
        .formula_used (formula_used)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Corner n sits at offset (n[0], n[1], n[2]); it is inside when its grid
    // position meets all three triangle inequalities. The count and the
    // corner tests pick a formula and the order in which corners fill its
    // slots a..h.
    function automatic cell_volume_t integrate_cell(input cube_t c);
        bit           in_region [N_CORNERS];
        int           inside_count;
        int           x;
        int           y;
        int           z;
        sel_t         sel;
        int           slot_corner [N_CORNERS];
        int           weight [N_CORNERS];
        longint       acc;
        cell_volume_t r;
        inside_count = 0;
        for (int n = 0; n < N_CORNERS; n++)
        begin
            x = int'(c.i) + (n & 1);
            y = int'(c.j) + ((n >> 1) & 1);
            z = int'(c.k) + ((n >> 2) & 1);
            in_region[n] = !(x > y + z || y > x + z || z > x + y);
            if (in_region[n])
            begin
                inside_count++;
            end
        end
        sel = SEL_NONE;
        case (inside_count)
            4:
            begin
                if (in_region[6])      sel = SEL_F2_G;
                else if (in_region[3]) sel = SEL_F2_D;
                else if (in_region[5]) sel = SEL_F2_F;
            end
            5: sel = SEL_F1;
            6:
            begin
                if (in_region[2])      sel = SEL_F3_A;
                else if (in_region[1]) sel = SEL_F3_B;
                else if (in_region[4]) sel = SEL_F3_G;
            end
            7:
            begin
                if (!in_region[1])      sel = SEL_F4_G;
                else if (!in_region[4]) sel = SEL_F4_D;
                else if (!in_region[2]) sel = SEL_F4_F;
            end
            8: sel = SEL_F5;
            default: sel = SEL_NONE;
        endcase

        weight = '{0, 0, 0, 0, 0, 0, 0, 0};
        r.formula = FORM_NONE;
        case (sel)
            SEL_F1:
            begin
                weight = '{33, 33, 33, 51, 33, 51, 51, 75};
                r.formula = FORM_1;
            end
            SEL_F2_G, SEL_F2_D, SEL_F2_F:
            begin
                weight = '{47, 19, 19, 5, 19, 5, 5, 1};
                r.formula = FORM_2;
            end
            SEL_F3_A, SEL_F3_B, SEL_F3_G:
            begin
                weight = '{70, 80, 80, 70, 38, 52, 52, 38};
                r.formula = FORM_3;
            end
            SEL_F4_G, SEL_F4_D, SEL_F4_F:
            begin
                weight = '{89, 85, 85, 71, 85, 71, 71, 43};
                r.formula = FORM_4;
            end
            SEL_F5:
            begin
                weight = '{90, 90, 90, 90, 90, 90, 90, 90};
                r.formula = FORM_5;
            end
            default:
            begin
                r.formula = FORM_NONE;
            end
        endcase

        case (sel)
            SEL_F2_G, SEL_F3_G, SEL_F4_G: slot_corner = '{6, 7, 4, 5, 2, 3, 0, 1};
            SEL_F2_D, SEL_F4_D:           slot_corner = '{3, 2, 1, 0, 7, 6, 5, 4};
            SEL_F2_F, SEL_F4_F:           slot_corner = '{5, 4, 7, 6, 1, 0, 3, 2};
            SEL_F3_A:                     slot_corner = '{3, 7, 2, 6, 1, 5, 0, 4};
            SEL_F3_B:                     slot_corner = '{5, 7, 1, 3, 4, 6, 0, 2};
            default:                      slot_corner = '{0, 1, 2, 3, 4, 5, 6, 7};
        endcase

        acc = 0;
        for (int s = 0; s < N_CORNERS; s++)
        begin
            acc += longint'(weight[s]) * longint'($signed(c.p[slot_corner[s]]));
        end
        r.volume = acc[VOL_BITS-1:0];
        return r;
    endfunction

    function automatic logic [SMP_W-1:0] random_sample();
        case ($urandom_range(0, 5))
            0:       return {1'b0, {(SMP_W-1){1'b1}}};
            1:       return {1'b1, {(SMP_W-1){1'b0}}};
            2:       return SMP_W'($urandom_range(0, 200) - 100);
            default: return SMP_W'($urandom());
        endcase
    endfunction

    // Most cubes sit on or next to an inequality boundary, where the inside
    // count varies; the rest are tiny indices or plain noise.
    function automatic cube_t random_cube();
        cube_t c;
        int    trio [3];
        int    mode;
        int    a;
        int    b;
        int    s;
        int    rot;
        mode = $urandom_range(0, 99);
        rot  = $urandom_range(0, 2);
        a    = $urandom_range(0, IDX_MAX / 2);
        b    = $urandom_range(0, IDX_MAX / 2);
        if (mode < 45)
        begin
            s = a + b + $urandom_range(0, 4) - 2;
        end
        else if (mode < 70)
        begin
            // Two indices equal or one apart and a small third one lie on or next to two boundaries.
            s = $urandom_range(0, 2);
            a = $urandom_range(0, IDX_MAX);
            b = a + $urandom_range(0, 2) - 1;
        end
        else if (mode < 85)
        begin
            s = $urandom_range(0, 3);
            a = $urandom_range(0, 3);
            b = $urandom_range(0, 3);
        end
        else
        begin
            s = $urandom_range(0, IDX_MAX);
            a = $urandom_range(0, IDX_MAX);
            b = $urandom_range(0, IDX_MAX);
        end
        trio[rot]           = s;
        trio[(rot + 1) % 3] = a;
        trio[(rot + 2) % 3] = b;
        for (int n = 0; n < 3; n++)
        begin
            trio[n] = (trio[n] < 0) ? 0 : ((trio[n] > IDX_MAX) ? IDX_MAX : trio[n]);
        end
        c.i = IDX_W'(trio[0]);
        c.j = IDX_W'(trio[1]);
        c.k = IDX_W'(trio[2]);
        for (int n = 0; n < N_CORNERS; n++)
        begin
            c.p[n] = random_sample();
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Called at a rising edge; returns at the edge that took the beat.
    task automatic send_cube(input cube_t c);
        bit taken;
        start      <= 1'b1;
        index_i    <= c.i;
        index_j    <= c.j;
        index_k    <= c.k;
        corner_000 <= c.p[0];
        corner_100 <= c.p[1];
        corner_010 <= c.p[2];
        corner_110 <= c.p[3];
        corner_001 <= c.p[4];
        corner_101 <= c.p[5];
        corner_011 <= c.p[6];
        corner_111 <= c.p[7];
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (!busy)
            begin
                taken = 1'b1;
                pending_volumes.push_back(integrate_cell(c));
            end
            @(posedge clk);
        end
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_results_drained();
        int guard;
        start <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (pending_volumes.size() != 0 && guard < DRAIN_LIMIT);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_volumes.size() == 0)
            begin
                report_mismatch("result with nothing expected", 0, longint'(volume_x720));
            end
            else
            begin
                oldest_volume = pending_volumes.pop_front();
                if (volume_x720 !== oldest_volume.volume)
                begin
                    report_mismatch("volume_x720", longint'(oldest_volume.volume),
                                    longint'(volume_x720));
                end
                if (formula_used !== oldest_volume.formula)
                begin
                    report_mismatch("formula_used", longint'(oldest_volume.formula),
                                    longint'(formula_used));
                end
            end
        end
    end

    // Full-scale samples on cubes that use every corner, plus alternating
    // bit patterns so that each sample bit is seen at both levels.
    task automatic test_extremes();
        cube_t c;
        logic [SMP_W-1:0] pos_max;
        logic [SMP_W-1:0] neg_min;
        pos_max = {1'b0, {(SMP_W-1){1'b1}}};
        neg_min = {1'b1, {(SMP_W-1){1'b0}}};
        for (int v = 0; v < 6; v++)
        begin
            c.i = (v % 2 == 0) ? IDX_W'(IDX_MAX) : '0;
            c.j = c.i;
            c.k = c.i;
            for (int n = 0; n < N_CORNERS; n++)
            begin
                case (v)
                    0, 1:    c.p[n] = pos_max;
                    2, 3:    c.p[n] = neg_min;
                    4:       c.p[n] = (n % 2 == 0) ? {(SMP_W/2){2'b01}} : {(SMP_W/2){2'b10}};
                    default: c.p[n] = (n % 2 == 0) ? pos_max : neg_min;
                endcase
            end
            send_cube(c);
        end
    endtask

    // One cube per formula and corner choice, plus counts below four.
    task automatic test_cell_cases();
        cube_t c;
        int    cases [15][3];
        cases = '{
            '{0, 0, 0},          // five corners inside
            '{IDX_MAX, 0, 0},    // nothing inside
            '{302, 100, 200},    // a single corner inside
            '{299, 100, 200},    // all eight inside
            '{301, 100, 200},    // four inside, corner 011 test
            '{100, 200, 301},    // four inside, corner 110 test
            '{100, 301, 200},    // four inside, corner 101 test
            '{5, 0, 5},          // six inside, corner 010 test
            '{0, 5, 5},          // six inside, corner 100 test
            '{5, 5, 0},          // six inside, corner 001 test
            '{IDX_MAX, IDX_MAX, 0},
            '{300, 100, 200},    // seven inside, corner 100 out
            '{100, 200, 300},    // seven inside, corner 001 out
            '{100, 300, 200},    // seven inside, corner 010 out
            '{0, IDX_MAX, IDX_MAX}
        };
        foreach (cases[n])
        begin
            c.i = IDX_W'(cases[n][0]);
            c.j = IDX_W'(cases[n][1]);
            c.k = IDX_W'(cases[n][2]);
            for (int m = 0; m < N_CORNERS; m++)
            begin
                c.p[m] = random_sample();
            end
            send_cube(c);
        end
    endtask

    task automatic test_random_cubes();
        int burst_left;
        burst_left = 0;
        for (int n = 0; n < RANDOM_CUBES; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                begin
                    idle_for($urandom_range(1, 7));
                end
            end
            send_cube(random_cube());
            burst_left--;
            if (n == RANDOM_CUBES / 2)
            begin
                wait_results_drained();
            end
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        index_i    <= '0;
        index_j    <= '0;
        index_k    <= '0;
        corner_000 <= '0;
        corner_100 <= '0;
        corner_010 <= '0;
        corner_110 <= '0;
        corner_001 <= '0;
        corner_101 <= '0;
        corner_011 <= '0;
        corner_111 <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_cell_cases();
        wait_results_drained();
        test_random_cubes();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (pending_volumes.size() != 0)
        begin
            oldest_volume = pending_volumes.pop_front();
            report_mismatch("result never arrived", longint'(oldest_volume.volume), 0);
        end
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
